// File: src/svalloc_pkg.sv
// ----------------------------------------------------------------------------
// svalloc_pkg
// Shared types, codes and defaults of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package svalloc_pkg;

   // Default sizes
   localparam int VOICES_DEF = 8;
   localparam int OSC_DEF    = 4;

   // Width of the oscillator enable register
   localparam int MASK_W = 4;
   localparam logic [MASK_W-1:0] MASK_RESET = 4'b0001;

   // Operation codes
   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_REPORT   = 2'd2;

   // Envelope stage codes
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ATTACK  = 3'd1;
   localparam logic [2:0] ST_RELEASE = 3'd4;

   // Request item
   typedef struct packed {
      logic [1:0]  operation;
      logic [6:0]  note;
      logic [31:0] time_now;
      logic [2:0]  report_voice;
      logic [1:0]  report_osc;
      logic [2:0]  report_stage;
   } req_item_type;

   // Response item
   typedef struct packed {
      logic [2:0] voice_chosen;
      logic       found;
      logic       stolen;
   } rsp_item_type;

   // Sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_COMMIT
   } seq_state_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic accept;
      logic scan;
      logic first;
      logic commit;
   } seq_ctl_type;

endpackage

// File: src/synth_voice_allocator_top.sv
// ----------------------------------------------------------------------------
// synth_voice_allocator_top
// Polyphonic voice allocator with oldest-voice stealing.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start; the item is taken at a clock edge where
//   start is high and busy is low. busy stays high while the item is worked.
//   Note on and note off walk the voices one per cycle through a single
//   start-time comparator, then update the tables in a single commit step.
//   Each item gives exactly one response: rsp_valid is high for one cycle
//   with rsp_item, and the receiver must take it then (it cannot stall).
//   The next item can be taken in the response cycle, so the voice scan
//   sets how often note on and note off items can be taken.
//   The enable register is written through csr_valid/csr_wdata (csr_ready
//   is always high) and should only change while the block is idle.
//   Synchronous reset empties all voices (note 0, time 0, stages idle),
//   sets the enable register to oscillator 0 only and drops busy and
//   rsp_valid. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module synth_voice_allocator_top import svalloc_pkg::*; #(
   parameter int VOICES      = VOICES_DEF,
   parameter int OSCILLATORS = OSC_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_item_type      req_item,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [MASK_W-1:0] csr_wdata
);

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

   seq_ctl_type      ctl;
   logic [IDX_W-1:0] idx;

   assign csr_ready = 1'b1;

   // Sequencer
   svalloc_ctrl #(
      .VOICES (VOICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_item.operation),
      .busy      (busy),
      .ctl       (ctl),
      .idx       (idx)
   );

   // Tables and scan datapath
   svalloc_dp #(
      .VOICES      (VOICES),
      .OSCILLATORS (OSCILLATORS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .idx       (idx),
      .req_item  (req_item),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// File: src/svalloc_ctrl.sv
// ----------------------------------------------------------------------------
// svalloc_ctrl
// Sequencer: accepts an item, walks the voice index once for note on and
// note off (other operations skip the walk), then issues a single commit step.
// ----------------------------------------------------------------------------
module svalloc_ctrl import svalloc_pkg::*; #(
   parameter int VOICES = VOICES_DEF,
   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       operation,
   output logic             busy,
   output seq_ctl_type      ctl,
   output logic [IDX_W-1:0] idx
);

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             last;

   assign accept = start && (state_ff == SEQ_IDLE);
   assign last   = (idx_ff == IDX_W'(VOICES - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (operation == OP_NOTE_ON || operation == OP_NOTE_OFF) begin
                  state_in = SEQ_SCAN;
               end else begin
                  state_in = SEQ_COMMIT;
               end
            end
         end
         SEQ_SCAN: begin
            if (last) begin
               state_in = SEQ_COMMIT;
            end
         end
         SEQ_COMMIT: state_in = SEQ_IDLE;
         default:    state_in = SEQ_IDLE;
      endcase
   end

   // Scan index: restart on accept, advance while scanning
   always_comb begin
      idx_in = idx_ff;
      if (accept) begin
         idx_in = '0;
      end else if (state_ff == SEQ_SCAN && !last) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Outputs
   always_comb begin
      ctl.accept = accept;
      ctl.scan   = 1'b0;
      ctl.commit = 1'b0;
      ctl.first  = (idx_ff == '0);
      busy       = 1'b1;
      case (state_ff)
         SEQ_IDLE:   busy       = 1'b0;
         SEQ_SCAN:   ctl.scan   = 1'b1;
         SEQ_COMMIT: ctl.commit = 1'b1;
         default:    busy       = 1'b0;
      endcase
   end

   assign idx = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// File: src/svalloc_dp.sv
// ----------------------------------------------------------------------------
// svalloc_dp
// Voice tables, shared start-time comparator, scan trackers and response
// register of the voice allocator.
// ----------------------------------------------------------------------------
module svalloc_dp import svalloc_pkg::*; #(
   parameter int VOICES      = VOICES_DEF,
   parameter int OSCILLATORS = OSC_DEF,
   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1,
   localparam int OSC_W = (OSCILLATORS > 1) ? $clog2(OSCILLATORS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  seq_ctl_type       ctl,
   input  logic [IDX_W-1:0]  idx,
   input  req_item_type      req_item,
   input  logic              csr_we,
   input  logic [MASK_W-1:0] csr_wdata,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item
);

   typedef logic [OSCILLATORS-1:0][2:0] row_type;

   logic [MASK_W-1:0] mask_ff;
   req_item_type      item_ff;
   logic [6:0]        note_ff [VOICES];
   logic [31:0]       time_ff [VOICES];
   row_type           env_ff  [VOICES];

   // Scan trackers
   logic              have_ff;
   logic [IDX_W-1:0]  pick_ff;
   row_type           pick_row_ff;
   logic [IDX_W-1:0]  old_ff;
   logic [31:0]       best_time_ff;

   logic              rsp_valid_ff;
   rsp_item_type      rsp_ff, rsp_in;

   logic [OSCILLATORS-1:0] osc_en;
   row_type           row_rd;
   logic [31:0]       time_rd;
   logic              older;
   logic              row_idle;
   logic              row_active;
   logic              is_on;
   logic              is_off;
   logic              take_old;
   logic              take_pick;
   logic [IDX_W-1:0]  commit_v;
   logic              rep_ok;
   logic [IDX_W-1:0]  rep_v;
   logic [OSC_W-1:0]  rep_o;

   // Oscillators beyond the register width are never enabled
   assign osc_en = OSCILLATORS'({{OSCILLATORS{1'b0}}, mask_ff});

   assign is_on  = (item_ff.operation == OP_NOTE_ON);
   assign is_off = (item_ff.operation == OP_NOTE_OFF);

   // Read the voice under scan
   assign row_rd  = env_ff[idx];
   assign time_rd = time_ff[idx];

   // Shared comparator: scanned start time against the tracked one
   assign older = (time_rd < best_time_ff);

   always_comb begin
      row_idle   = 1'b1;
      row_active = 1'b0;
      for (int o = 0; o < OSCILLATORS; o++) begin
         if (osc_en[o] && row_rd[o] != ST_IDLE) begin
            row_idle = 1'b0;
            if (row_rd[o] != ST_RELEASE) begin
               row_active = 1'b1;
            end
         end
      end
   end

   // Note on tracks the oldest voice and an idle voice; note off tracks the oldest match
   assign take_old  = ctl.scan && is_on && (ctl.first || older);
   assign take_pick = ctl.scan && (is_on ? row_idle
                    : (is_off && note_ff[idx] == item_ff.note && row_active
                       && (!have_ff || older)));

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         item_ff <= req_item;
      end
      if (take_old || (take_pick && is_off)) begin
         best_time_ff <= time_rd;
      end
      if (take_old) begin
         old_ff <= idx;
      end
      if (take_pick) begin
         pick_ff     <= idx;
         pick_row_ff <= row_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.accept) begin
         have_ff <= 1'b0;
      end else if (take_pick) begin
         have_ff <= 1'b1;
      end
   end

   // Commit target and stage report decode
   assign commit_v = (is_on && !have_ff) ? old_ff : pick_ff;
   assign rep_ok   = (32'(item_ff.report_voice) < VOICES)
                  && (32'(item_ff.report_osc) < OSCILLATORS)
                  && (item_ff.report_stage <= ST_RELEASE);
   assign rep_v    = IDX_W'(item_ff.report_voice);
   assign rep_o    = OSC_W'(item_ff.report_osc);

   // Voice tables and enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
         for (int v = 0; v < VOICES; v++) begin
            note_ff[v] <= '0;
            time_ff[v] <= '0;
            env_ff[v]  <= '0;
         end
      end else begin
         if (csr_we) begin
            mask_ff <= csr_wdata;
         end
         if (ctl.commit) begin
            if (is_on) begin
               note_ff[commit_v] <= item_ff.note;
               time_ff[commit_v] <= item_ff.time_now;
               for (int o = 0; o < OSCILLATORS; o++) begin
                  if (osc_en[o]) begin
                     env_ff[commit_v][o] <= ST_ATTACK;
                  end
               end
            end else if (is_off) begin
               for (int o = 0; o < OSCILLATORS; o++) begin
                  if (have_ff && osc_en[o] && pick_row_ff[o] != ST_IDLE) begin
                     env_ff[pick_ff][o] <= ST_RELEASE;
                  end
               end
            end else if (item_ff.operation == OP_REPORT && rep_ok) begin
               env_ff[rep_v][rep_o] <= item_ff.report_stage;
            end
         end
      end
   end

   // Response
   always_comb begin
      rsp_in = '0;
      if (is_on) begin
         rsp_in.voice_chosen = 3'(commit_v);
         rsp_in.found        = 1'b1;
         rsp_in.stolen       = !have_ff;
      end else if (is_off && have_ff) begin
         rsp_in.voice_chosen = 3'(pick_ff);
         rsp_in.found        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.commit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: src/svalloc_checker.sv
// ----------------------------------------------------------------------------
// svalloc_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module svalloc_checker import svalloc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   // An accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Responses never come back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // Finishing an item shows its response
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   // The response cycle is an idle cycle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   // No voice chosen means voice 0 and no steal
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.found) |-> (!rsp_item.stolen && rsp_item.voice_chosen == 3'd0))
      else $error("response without a voice carries voice or steal");

endmodule

bind synth_voice_allocator_top svalloc_checker u_svalloc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
